>>> rtl/sorted_set_table_macros.svh
// Assertion macros for the sorted set table port checker.
`ifndef SORTED_SET_TABLE_MACROS_SVH
`define SORTED_SET_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define SST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted_set_table check failed");

// Next-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define SST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted_set_table check failed");

`endif

>>> rtl/sst_pkg.sv
// Shared types and constants of the sorted set table.
`timescale 1ns / 1ps
`default_nettype none
package sst_pkg;

  localparam int DEPTH = 64;
  localparam int KEY_W = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMD_W = 2;
  localparam int KEY_PORT_W = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } sst_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK   = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } sst_status_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } sst_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_SRCH,
    S_APPLY,
    S_RESP
  } sst_state_e;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    sst_op_e          op;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
    logic [KEY_W-1:0] key;
    logic             sgn;
  } sst_ctl_t;

endpackage
`default_nettype wire

>>> rtl/sst_cell.sv
// One table entry: key register, neighbor shift and compare against the request key.
`timescale 1ns / 1ps
`default_nettype none
module sst_cell (
  input  wire logic                    clk_i,
  input  wire sst_pkg::sst_ctl_t       ctl_i,
  input  wire logic [sst_pkg::IDX_W-1:0] idx_i,
  input  wire logic [sst_pkg::KEY_W-1:0] prev_key_i,
  input  wire logic [sst_pkg::KEY_W-1:0] next_key_i,
  output logic [sst_pkg::KEY_W-1:0]      key_o,
  output logic                           lt_o,
  output logic                           eq_o
);
  import sst_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;
  logic [KEY_W-1:0] flip;
  logic [KEY_W-1:0] want, have;
  logic [CNT_W-1:0] idx_w, idx_nx;
  logic             lt_q, eq_q;

  assign idx_w  = CNT_W'(idx_i);
  assign idx_nx = idx_w + CNT_W'(1);

  always_comb begin
    key_d = key_q;
    case (ctl_i.op)
      OP_INS: begin
        if (idx_w == ctl_i.pos) begin
          key_d = ctl_i.key;
        end else if (idx_w > ctl_i.pos && idx_w <= ctl_i.cnt) begin
          key_d = prev_key_i;
        end
      end
      OP_DEL: begin
        if (idx_w >= ctl_i.pos && idx_nx < ctl_i.cnt) begin
          key_d = next_key_i;
        end
      end
      default: key_d = key_q;
    endcase
  end

  // Flipping the sign bit maps two's complement order onto unsigned order.
  assign flip = KEY_W'(ctl_i.sgn) << (KEY_W - 1);
  assign want = ctl_i.key ^ flip;
  assign have = key_q ^ flip;

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    lt_q  <= want < have;
    eq_q  <= want == have;
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule
`default_nettype wire

>>> rtl/sst_ctrl.sv
// Sequencer: handshakes, binary search over the cell flags, entry count and result register.
`timescale 1ns / 1ps
`default_nettype none
module sst_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [sst_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [sst_pkg::KEY_PORT_W-1:0] key_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [sst_pkg::STATUS_W-1:0]       status_o,
  output logic [sst_pkg::POS_W-1:0]          position_o,
  output logic [sst_pkg::POS_W-1:0]          entry_count_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_data_i,
  input  wire logic [sst_pkg::DEPTH-1:0]     lt_i,
  input  wire logic [sst_pkg::DEPTH-1:0]     eq_i,
  output sst_pkg::sst_ctl_t                  ctl_o
);
  import sst_pkg::*;

  sst_state_e       state_q, state_d;
  sst_cmd_e         cmd_q, cmd_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d, count_q, count_d;
  logic             hit_q, hit_d;
  logic             sgn_q;
  sst_status_e      status_q, status_d;
  logic             out_valid_q, out_valid_d;
  sst_status_e      out_status_q;
  logic [CNT_W-1:0] out_pos_q, out_cnt_q;
  logic             in_acc, out_load, done;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] mid;
  logic [IDX_W-1:0] midx;
  logic             ins_ok, del_ok;

  assign in_acc = in_valid_i && !in_stall_o;
  assign out_load = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);

  // One probe of the search per cycle; mid is below hi, so it always names a cell.
  assign sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid  = sum[CNT_W:1];
  assign midx = mid[IDX_W-1:0];
  assign done = (lo_q >= hi_q) || hit_q;

  assign ins_ok = (cmd_q == CMD_INSERT) && !hit_q && (count_q < CNT_W'(DEPTH));
  assign del_ok = (cmd_q == CMD_DELETE) && hit_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (sst_cmd_e'(cmd_i) == CMD_CLEAR) ? S_RESP : S_CMP;
        end
      end
      S_CMP:   state_d = S_SRCH;
      S_SRCH:  if (done) state_d = S_APPLY;
      S_APPLY: state_d = S_RESP;
      S_RESP:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_comb begin
    cmd_d    = cmd_q;
    key_d    = key_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    hit_d    = hit_q;
    count_d  = count_q;
    status_d = status_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d    = sst_cmd_e'(cmd_i);
          key_d    = key_i[KEY_W-1:0];
          lo_d     = '0;
          hi_d     = count_q;
          hit_d    = 1'b0;
          status_d = STS_OK;
          if (sst_cmd_e'(cmd_i) == CMD_CLEAR) begin
            count_d = '0;
          end
        end
      end
      S_SRCH: begin
        if (!done) begin
          if (lt_i[midx]) begin
            hi_d = mid;
          end else if (eq_i[midx]) begin
            hit_d = 1'b1;
            lo_d  = mid;
          end else begin
            lo_d = mid + CNT_W'(1);
          end
        end
      end
      S_APPLY: begin
        case (cmd_q)
          CMD_LOOKUP: status_d = hit_q ? STS_OK : STS_MISS;
          CMD_INSERT: begin
            if (hit_q) begin
              status_d = STS_MISS;
            end else if (!ins_ok) begin
              status_d = STS_FULL;
            end else begin
              status_d = STS_OK;
              count_d  = count_q + CNT_W'(1);
            end
          end
          CMD_DELETE: begin
            if (del_ok) begin
              status_d = STS_OK;
              count_d  = count_q - CNT_W'(1);
            end else begin
              status_d = STS_MISS;
            end
          end
          default: status_d = STS_OK;
        endcase
      end
      default: ;
    endcase
  end

  // Outputs toward the cells and the input side.
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    ctl_o.op   = OP_HOLD;
    ctl_o.pos  = lo_q;
    ctl_o.cnt  = count_q;
    ctl_o.key  = key_q;
    ctl_o.sgn  = sgn_q;
    case (state_q)
      S_APPLY: begin
        if (ins_ok) begin
          ctl_o.op = OP_INS;
        end else if (del_ok) begin
          ctl_o.op = OP_DEL;
        end
      end
      default: ctl_o.op = OP_HOLD;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      sgn_q       <= 1'b0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      if (cfg_valid_i && cfg_ready_o) begin
        sgn_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    status_q <= status_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_pos_q    <= lo_q;
      out_cnt_q    <= count_q;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign position_o    = POS_W'(out_pos_q);
  assign entry_count_o = POS_W'(out_cnt_q);

endmodule
`default_nettype wire

>>> rtl/sorted_set_table.sv
// Top level of the sorted set table: controller and the row of key cells.
//
//  channel   direction  handshake               payload
//  in        input      in_valid_i / in_stall_o  cmd_i, key_i
//  out       output     out_valid_o / out_stall_i status_o, position_o, entry_count_o
//  cfg       input      cfg_valid_i / cfg_ready_o cfg_data_i (signed_keys)
//
// A clear goes straight to the response state; lookup, insert and delete pass through
// the compare, search, apply and response states in turn.
// The search loop probes one cell flag per cycle; insert and delete shift the whole row
// in the apply state. Reset empties the set and selects unsigned compares.
// A result waits in the output register under out_stall_i while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none
module sorted_set_table (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [sst_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [sst_pkg::KEY_PORT_W-1:0] key_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [sst_pkg::STATUS_W-1:0]       status_o,
  output logic [sst_pkg::POS_W-1:0]          position_o,
  output logic [sst_pkg::POS_W-1:0]          entry_count_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_data_i
);
  import sst_pkg::*;

  sst_ctl_t         ctl;
  logic [KEY_W-1:0] keys [DEPTH];
  logic [DEPTH-1:0] lt, eq;

  sst_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .key_i         (key_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .position_o    (position_o),
    .entry_count_o (entry_count_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .lt_i          (lt),
    .eq_i          (eq),
    .ctl_o         (ctl)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] prev_key, next_key;

    // The end cells never take a key from beyond the row.
    if (i == 0) begin : g_first
      assign prev_key = '0;
    end else begin : g_prev
      assign prev_key = keys[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_key = '0;
    end else begin : g_next
      assign next_key = keys[i+1];
    end

    sst_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .idx_i      (IDX_W'(i)),
      .prev_key_i (prev_key),
      .next_key_i (next_key),
      .key_o      (keys[i]),
      .lt_o       (lt[i]),
      .eq_o       (eq[i])
    );
  end

endmodule
`default_nettype wire

>>> rtl/sst_checker.sv
// Port-level checker for the sorted set table and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_set_table_macros.svh"
module sst_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_o,
  input  wire logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  input  wire logic [sst_pkg::STATUS_W-1:0]  status_o,
  input  wire logic [sst_pkg::POS_W-1:0]     position_o,
  input  wire logic [sst_pkg::POS_W-1:0]     entry_count_o
);
  import sst_pkg::*;

  // A result held under stall stays valid.
  `SST_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  // One request at a time: the input side closes right after a request.
  `SST_ASSERT_NEXT(a_one_at_a_time, in_valid_i && !in_stall_o, in_stall_o)
  // The reported position never lies beyond the entries held.
  `SST_ASSERT_NOW(a_pos_range, out_valid_o, position_o <= entry_count_o)
  // A full refusal only happens with every entry in use.
  `SST_ASSERT_NOW(a_full_count, out_valid_o && (status_o == STS_FULL),
                  entry_count_o == POS_W'(DEPTH))

endmodule

bind sorted_set_table sst_checker u_sst_checker (.*);
`default_nettype wire

>>> tb/sorted_set_table_checker.sv
// Checker for the sorted set table: predicts every result and compares it with the block.
`timescale 1ns / 1ps
module sorted_set_table_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic                           in_stall_i,
  input  wire logic [sst_pkg::CMD_W-1:0]      cmd_i,
  input  wire logic [sst_pkg::KEY_PORT_W-1:0] key_i,
  input  wire logic                           out_valid_i,
  input  wire logic                           out_stall_i,
  input  wire logic [sst_pkg::STATUS_W-1:0]   status_i,
  input  wire logic [sst_pkg::POS_W-1:0]      position_i,
  input  wire logic [sst_pkg::POS_W-1:0]      entry_count_i,
  input  wire logic                           cfg_valid_i,
  input  wire logic                           cfg_ready_i,
  input  wire logic                           cfg_data_i,
  output int                                  pending_o,
  output int                                  errors_o
);
  import sst_pkg::*;

  typedef struct packed {
    sst_status_e      status;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] count;
  } set_result_t;

  logic [KEY_W-1:0] held_keys [DEPTH];
  int               held_cnt;
  bit               signed_mode;
  set_result_t      awaited_q [$];
  set_result_t      got;
  set_result_t      want;

  // Flipping the sign bit turns a two's complement order into an unsigned one.
  function automatic logic [KEY_W-1:0] rank_of(logic [KEY_W-1:0] k);
    return signed_mode ? (k ^ {1'b1, {(KEY_W-1){1'b0}}}) : k;
  endfunction

  // The probe sequence must match the block exactly: after a change of compare
  // mode the stored keys are no longer sorted, and the answer depends on the path.
  function automatic int find_slot(logic [KEY_W-1:0] key, output bit hit);
    int lo;
    int hi;
    int mid;
    logic [KEY_W-1:0] target;
    logic [KEY_W-1:0] probe;
    lo = 0;
    hi = held_cnt;
    target = rank_of(key);
    hit = 1'b0;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      probe = rank_of(held_keys[mid]);
      if (target < probe) begin
        hi = mid;
      end else if (target > probe) begin
        lo = mid + 1;
      end else begin
        hit = 1'b1;
        return mid;
      end
    end
    return lo;
  endfunction

  function automatic set_result_t apply_request(sst_cmd_e cmd, logic [KEY_W-1:0] key);
    set_result_t r;
    bit hit;
    int slot;
    r.status = STS_OK;
    r.position = '0;
    if (cmd == CMD_CLEAR) begin
      held_cnt = 0;
    end else begin
      slot = find_slot(key, hit);
      r.position = POS_W'(slot);
      case (cmd)
        CMD_LOOKUP: begin
          r.status = hit ? STS_OK : STS_MISS;
        end
        CMD_INSERT: begin
          if (hit) begin
            r.status = STS_MISS;
          end else if (held_cnt >= DEPTH) begin
            r.status = STS_FULL;
          end else begin
            for (int i = held_cnt; i > slot; i--) held_keys[i] = held_keys[i-1];
            held_keys[slot] = key;
            held_cnt++;
          end
        end
        default: begin
          if (!hit) begin
            r.status = STS_MISS;
          end else begin
            for (int i = slot; i + 1 < held_cnt; i++) held_keys[i] = held_keys[i+1];
            held_cnt--;
          end
        end
      endcase
    end
    r.count = POS_W'(held_cnt);
    return r;
  endfunction

  task automatic note_error(bit orphan, set_result_t exp_r, set_result_t act_r);
    if (errors_o < 10) begin
      if (orphan) begin
        $display("%0t: result with no request pending: status %0d position %0d count %0d",
                 $realtime, act_r.status, act_r.position, act_r.count);
      end else begin
        $display("%0t: mismatch: status %0d/%0d position %0d/%0d count %0d/%0d (exp/act)",
                 $realtime, exp_r.status, act_r.status, exp_r.position, act_r.position,
                 exp_r.count, act_r.count);
      end
    end
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt = 0;
      signed_mode = 1'b0;
      awaited_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) signed_mode = cfg_data_i;
      // Results leave before new requests are booked, as no request is
      // answered in the cycle that it is taken.
      if (out_valid_i && !out_stall_i) begin
        got.status = sst_status_e'(status_i);
        got.position = position_i;
        got.count = entry_count_i;
        if (awaited_q.size() == 0) begin
          note_error(1'b1, got, got);
        end else begin
          want = awaited_q.pop_front();
          if (got.status !== want.status || got.position !== want.position ||
              got.count !== want.count) begin
            note_error(1'b0, want, got);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_q.push_back(apply_request(sst_cmd_e'(cmd_i), key_i[KEY_W-1:0]));
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the sorted set table testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import sst_pkg::*;

  localparam int POOL_SIZE = 96;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 160;
  localparam int SETTLE_CYCLES = 12;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [CMD_W-1:0]      cmd_i;
  logic [KEY_PORT_W-1:0] key_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [STATUS_W-1:0]   status_o;
  logic [POS_W-1:0]      position_o;
  logic [POS_W-1:0]      entry_count_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic                  cfg_data_i;
  int                    pending;
  int                    errors;

  logic [KEY_PORT_W-1:0] key_pool [POOL_SIZE];
  int                    send_calm;
  int                    recv_calm;

  sorted_set_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .key_i         (key_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .position_o    (position_o),
    .entry_count_o (entry_count_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  sorted_set_table_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .cmd_i         (cmd_i),
    .key_i         (key_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_i      (status_o),
    .position_i    (position_o),
    .entry_count_i (entry_count_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending),
    .errors_o      (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("testbench: errors");
    $finish;
  end

  // Mostly random waits, with occasional runs of back-to-back transfers.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  task automatic send_request(sst_cmd_e cmd, logic [KEY_PORT_W-1:0] key);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    key_i <= key;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Returns at a rising edge once every request has been answered and the
  // block has had time to settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_sign_mode(bit mode);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Clusters near zero, the sign boundary and the top make signed and unsigned
  // orders disagree often.
  task automatic fill_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      case ($urandom_range(0, 3))
        0: key_pool[i] = $urandom();
        1: key_pool[i] = $urandom_range(0, 40);
        2: key_pool[i] = 32'h8000_0000 + $urandom_range(0, 40) - 32'd20;
        default: key_pool[i] = 32'hFFFF_FFFF - $urandom_range(0, 40);
      endcase
    end
  endtask

  function automatic logic [KEY_PORT_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  // Kind 0 fills the table toward full, kind 1 keeps it level, kind 2 drains it.
  function automatic sst_cmd_e pick_cmd(int kind);
    int roll;
    roll = $urandom_range(0, 99);
    case (kind)
      0: begin
        if (roll < 75) return CMD_INSERT;
        if (roll < 90) return CMD_LOOKUP;
        if (roll < 99) return CMD_DELETE;
      end
      1: begin
        if (roll < 30) return CMD_LOOKUP;
        if (roll < 65) return CMD_INSERT;
        if (roll < 97) return CMD_DELETE;
      end
      default: begin
        if (roll < 25) return CMD_LOOKUP;
        if (roll < 50) return CMD_INSERT;
        if (roll < 98) return CMD_DELETE;
      end
    endcase
    return CMD_CLEAR;
  endfunction

  initial begin
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      int hold;
      hold = draw_wait(recv_calm);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin
    bit mode;
    send_calm = 0;
    recv_calm = 0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    cmd_i <= CMD_LOOKUP;
    key_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, extreme keys, duplicate insert, absent delete and clear.
    send_request(CMD_LOOKUP, 32'h0000_0000);
    send_request(CMD_DELETE, 32'h0000_0005);
    send_request(CMD_INSERT, 32'h0000_0000);
    send_request(CMD_INSERT, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 32'h8000_0000);
    send_request(CMD_INSERT, 32'h7FFF_FFFF);
    send_request(CMD_INSERT, 32'h0000_0000);
    send_request(CMD_LOOKUP, 32'h8000_0000);
    send_request(CMD_LOOKUP, 32'h0000_0001);
    send_request(CMD_DELETE, 32'h7FFF_FFFF);
    send_request(CMD_DELETE, 32'h7FFF_FFFF);
    send_request(CMD_CLEAR, 32'hFFFF_FFFF);
    send_request(CMD_LOOKUP, 32'h0000_0000);
    send_request(CMD_INSERT, 32'h8000_0000);
    send_request(CMD_INSERT, 32'h7FFF_FFFF);
    send_request(CMD_INSERT, 32'h0000_0001);

    // Switch to signed compares with keys still held in unsigned order.
    wait_drained();
    write_sign_mode(1'b1);
    send_request(CMD_LOOKUP, 32'h8000_0000);
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 32'hFFFF_FFFF);
    send_request(CMD_DELETE, 32'h0000_0001);
    send_request(CMD_CLEAR, 32'h0000_0000);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      mode = (p < 4) ? bit'(p % 2) : bit'($urandom_range(0, 1));
      write_sign_mode(mode);
      fill_pool();
      if (p % 2 == 0) send_request(CMD_CLEAR, pick_key());
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(pick_cmd(p % 3), pick_key());
    end

    wait_drained();
    @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
